>>> design/sgf_tok_pkg.sv
// Shared types, codes and character constants of the SGF tokenizer.
`default_nettype none

package sgf_tok_pkg;

    typedef enum logic [3:0] {
        ST_START       = 4'd0,
        ST_GROUP       = 4'd1,
        ST_NODE        = 4'd2,
        ST_NAME        = 4'd3,
        ST_VALUE       = 4'd4,
        ST_ESCAPE      = 4'd5,
        ST_AFTER_VALUE = 4'd6,
        ST_BETWEEN     = 4'd7,
        ST_CLOSED      = 4'd8,
        ST_DONE        = 4'd9,
        ST_FAILED      = 4'd10
    } t_state;

    typedef enum logic [2:0] {
        EV_NODE_OPEN   = 3'd0,
        EV_NAME_CHAR   = 3'd1,
        EV_PROP_START  = 3'd2,
        EV_VALUE_CHAR  = 3'd3,
        EV_VALUE_END   = 3'd4,
        EV_NODE_CLOSE  = 3'd5,
        EV_DONE        = 3'd6,
        EV_ERROR       = 3'd7
    } t_event;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DELETE    = 8'h7F;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] char_out;
        logic       semicolon_follows;
    } t_result;

    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_item;

    typedef struct packed {
        logic   any;
        t_item  item;
        t_state nxt;
    } t_dec;

    typedef struct packed {
        logic   any;
        t_result res;
        t_state nxt;
    } t_between;

    function automatic t_result mk_res(t_event ev, logic [7:0] ch, logic semi);
        t_result r;
        r.event_res         = ev;
        r.char_out          = ch;
        r.semicolon_follows = semi;
        return r;
    endfunction

    function automatic logic is_ctrl(logic [7:0] c);
        return (c < CH_SPACE) || (c == CH_DELETE);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

endpackage

`default_nettype wire

>>> design/sgf_tok_decode.sv
// Combinational next-state and event decoder for one input byte.
`default_nettype none

module sgf_tok_decode
    import sgf_tok_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_file,
    output t_dec       o_dec
);

    t_between btw;

    // Token that follows a value, possibly after skipped control bytes.
    always_comb begin
        btw.any = 1'b0;
        btw.res = mk_res(EV_ERROR, 8'h00, 1'b0);
        btw.nxt = ST_FAILED;
        if (is_ctrl(i_char_code)) begin
            btw.nxt = ST_BETWEEN;
        end else if (i_char_code == CH_RPAREN) begin
            btw.any = 1'b1;
            btw.res = mk_res(EV_NODE_CLOSE, 8'h00, 1'b0);
            btw.nxt = ST_CLOSED;
        end else if (i_char_code == CH_SEMICOLON) begin
            btw.nxt = ST_NODE;
        end else if (i_char_code == CH_LPAREN) begin
            btw.nxt = ST_GROUP;
        end else if (i_char_code == CH_LBRACKET) begin
            btw.any = 1'b1;
            btw.res = mk_res(EV_PROP_START, 8'h00, 1'b0);
            btw.nxt = ST_VALUE;
        end else if (is_upper(i_char_code)) begin
            btw.any = 1'b1;
            btw.res = mk_res(EV_NAME_CHAR, i_char_code, 1'b0);
            btw.nxt = ST_NAME;
        end else begin
            btw.any = 1'b1;
        end
    end

    always_comb begin
        t_result err;
        err = mk_res(EV_ERROR, 8'h00, 1'b0);
        o_dec.any       = 1'b0;
        o_dec.item.res0 = err;
        o_dec.item.res1 = err;
        o_dec.item.two  = 1'b0;
        o_dec.nxt       = i_state;
        if ((i_state == ST_DONE) || (i_state == ST_FAILED)) begin
            o_dec.nxt = i_state;
        end else if (i_end_of_file) begin
            o_dec.any = 1'b1;
            if (i_state == ST_CLOSED) begin
                o_dec.item.res0 = mk_res(EV_DONE, 8'h00, 1'b0);
                o_dec.nxt       = ST_DONE;
            end else begin
                o_dec.nxt = ST_FAILED;
                if (i_state == ST_AFTER_VALUE) begin
                    o_dec.item.res0 = mk_res(EV_VALUE_END, 8'h00, 1'b0);
                    o_dec.item.two  = 1'b1;
                end
            end
        end else begin
            unique case (i_state)
                ST_START: begin
                    if (i_char_code == CH_LPAREN) begin
                        o_dec.nxt = ST_GROUP;
                    end else begin
                        o_dec.any = 1'b1;
                        o_dec.nxt = ST_FAILED;
                    end
                end
                ST_GROUP: begin
                    o_dec.any = 1'b1;
                    if (i_char_code == CH_SEMICOLON) begin
                        o_dec.item.res0 = mk_res(EV_NODE_OPEN, 8'h00, 1'b0);
                        o_dec.nxt       = ST_NODE;
                    end else begin
                        o_dec.nxt = ST_FAILED;
                    end
                end
                ST_NODE: begin
                    if (is_ctrl(i_char_code)) begin
                        o_dec.nxt = ST_NODE;
                    end else if (i_char_code == CH_LPAREN) begin
                        o_dec.nxt = ST_GROUP;
                    end else if (i_char_code == CH_LBRACKET) begin
                        o_dec.any       = 1'b1;
                        o_dec.item.res0 = mk_res(EV_PROP_START, 8'h00, 1'b0);
                        o_dec.nxt       = ST_VALUE;
                    end else if (is_upper(i_char_code)) begin
                        o_dec.any       = 1'b1;
                        o_dec.item.res0 = mk_res(EV_NAME_CHAR, i_char_code, 1'b0);
                        o_dec.nxt       = ST_NAME;
                    end else begin
                        o_dec.any = 1'b1;
                        o_dec.nxt = ST_FAILED;
                    end
                end
                ST_NAME: begin
                    o_dec.any = 1'b1;
                    if (i_char_code == CH_LBRACKET) begin
                        o_dec.item.res0 = mk_res(EV_PROP_START, 8'h00, 1'b0);
                        o_dec.nxt       = ST_VALUE;
                    end else if (is_upper(i_char_code)) begin
                        o_dec.item.res0 = mk_res(EV_NAME_CHAR, i_char_code, 1'b0);
                        o_dec.nxt       = ST_NAME;
                    end else begin
                        o_dec.nxt = ST_FAILED;
                    end
                end
                ST_VALUE: begin
                    if (i_char_code == CH_RBRACKET) begin
                        o_dec.nxt = ST_AFTER_VALUE;
                    end else begin
                        o_dec.any       = 1'b1;
                        o_dec.item.res0 = mk_res(EV_VALUE_CHAR, i_char_code, 1'b0);
                        o_dec.nxt       = (i_char_code == CH_BACKSLASH) ? ST_ESCAPE
                                                                        : ST_VALUE;
                    end
                end
                ST_ESCAPE: begin
                    o_dec.any       = 1'b1;
                    o_dec.item.res0 = mk_res(EV_VALUE_CHAR, i_char_code, 1'b0);
                    o_dec.nxt       = ST_VALUE;
                end
                ST_AFTER_VALUE: begin
                    o_dec.any       = 1'b1;
                    o_dec.item.res0 = mk_res(EV_VALUE_END, 8'h00,
                                             i_char_code == CH_SEMICOLON);
                    o_dec.item.res1 = btw.res;
                    o_dec.item.two  = btw.any;
                    o_dec.nxt       = btw.nxt;
                end
                ST_BETWEEN: begin
                    o_dec.any       = btw.any;
                    o_dec.item.res0 = btw.res;
                    o_dec.nxt       = btw.nxt;
                end
                ST_CLOSED: begin
                    if (is_ctrl(i_char_code)) begin
                        o_dec.nxt = ST_CLOSED;
                    end else if (i_char_code == CH_RPAREN) begin
                        o_dec.any       = 1'b1;
                        o_dec.item.res0 = mk_res(EV_NODE_CLOSE, 8'h00, 1'b0);
                        o_dec.nxt       = ST_CLOSED;
                    end else if (i_char_code == CH_LPAREN) begin
                        o_dec.nxt = ST_GROUP;
                    end else begin
                        o_dec.any = 1'b1;
                        o_dec.nxt = ST_FAILED;
                    end
                end
                default: begin
                    o_dec.nxt = ST_FAILED;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/sgf_tok_queue.sv
// Two-entry result queue that hands out the one or two results of each item.
`default_nettype none

module sgf_tok_queue
    import sgf_tok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_res,
    output logic       o_last
);

    t_item      r_items [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       r_sub;
    logic       n_pop;
    logic       n_beat;

    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_sub ? r_items[r_rd].res1 : r_items[r_rd].res0;
    assign o_last  = (r_sub == r_items[r_rd].two);
    assign n_beat  = o_valid && !i_stall;
    assign n_pop   = n_beat && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_items[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (n_pop) begin
                r_rd <= ~r_rd;
            end
            if (n_beat) begin
                r_sub <= ~o_last;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, n_pop};
        end
    end

endmodule

`default_nettype wire

>>> design/sgf_tokenizer_fsm.sv
// Top level of the SGF tokenizer: input register, parse state and result queue.
//
//  Channel  Direction  Handshake          Beat contents
//  input    in         i_valid / o_stall  i_char_code, i_end_of_file
//  result   out        o_valid / i_stall  o_event_res, o_char_out,
//                                         o_semicolon_follows, o_last
//
// A byte is held in the input register on acceptance, decoded from there and pushed
// into the result queue once the queue has room; its result beats leave the queue.
// One byte per cycle is sustained while the queue has room; a byte with two results
// gives two output beats, and the input stalls while both queue entries are full.
// The two-entry result queue lets the input keep flowing while a result is stalled.
// Synchronous reset returns the parser to waiting for an opening parenthesis.
`default_nettype none

module sgf_tokenizer_fsm
    import sgf_tok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_file,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_res,
    output logic [7:0] o_char_out,
    output logic       o_semicolon_follows,
    output logic       o_last
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eof;
    t_state     r_state;
    t_state     n_state;
    t_dec       dec;
    logic       q_room;
    logic       n_proc;
    logic       n_accept;
    t_result    q_res;

    sgf_tok_decode u_decode (
        .i_state       (r_state),
        .i_char_code   (r_char),
        .i_end_of_file (r_eof),
        .o_dec         (dec)
    );

    sgf_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_proc && dec.any),
        .i_item  (dec.item),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (q_res),
        .o_last  (o_last)
    );

    assign n_proc   = r_in_valid && q_room;
    assign o_stall  = r_in_valid && !q_room;
    assign n_accept = i_valid && !o_stall;

    assign o_event_res         = q_res.event_res;
    assign o_char_out          = q_res.char_out;
    assign o_semicolon_follows = q_res.semicolon_follows;

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_char <= i_char_code;
            r_eof  <= i_end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_START;
        end else begin
            r_state <= n_state;
            if (n_accept) begin
                r_in_valid <= 1'b1;
            end else if (n_proc) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        if (n_proc) begin
            n_state = dec.nxt;
        end
    end

endmodule

`default_nettype wire

>>> design/sgf_tok_checker.sv
// Port-level checker for the SGF tokenizer and its bind to the top level.
`default_nettype none

module sgf_tok_checker
    import sgf_tok_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_event_res,
    input logic [7:0] o_char_out,
    input logic       o_semicolon_follows,
    input logic       o_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res) && $stable(o_char_out)
            && $stable(o_semicolon_follows) && $stable(o_last))
        else $error("Stalled result beat changed.");

    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_event_res == EV_DONE || o_event_res == EV_ERROR)
            |=> !o_valid)
        else $error("Result beat after done or error.");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_DONE || o_event_res == EV_ERROR) |-> o_last)
        else $error("Done or error is not the last beat of its byte.");

    a_semi_only_value_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_semicolon_follows |-> o_event_res == EV_VALUE_END)
        else $error("Semicolon flag on an event other than value end.");

    a_char_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != EV_NAME_CHAR && o_event_res != EV_VALUE_CHAR
            |-> o_char_out == 8'h00)
        else $error("Character byte on an event without a character.");

endmodule

bind sgf_tokenizer_fsm sgf_tok_checker u_sgf_tok_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_event_res         (o_event_res),
    .o_char_out          (o_char_out),
    .o_semicolon_follows (o_semicolon_follows),
    .o_last              (o_last)
);

`default_nettype wire
